### rtl/maze_path_search_defines.svh
// Assertion macros for the maze path search checker.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef MAZE_PATH_SEARCH_DEFINES_SVH
`define MAZE_PATH_SEARCH_DEFINES_SVH

// same-cycle implication
`define MPS_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPS_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mps_pkg.sv
`timescale 1ns / 1ps

package mps_pkg;

   localparam int GRID_ROWS_DEF   = 16;
   localparam int GRID_COLS_DEF   = 16;
   localparam int STACK_DEPTH_DEF = 64;

   localparam int COORD_W = 5;
   localparam int DIR_W   = 3;
   localparam int OUT_W   = 2;
   localparam int LIM_W   = 7;
   localparam int NB_W    = 6;

   // compass codes as they appear on rsp_step_dir
   localparam logic [DIR_W-1:0] DIR_N  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_NE = 3'd1;
   localparam logic [DIR_W-1:0] DIR_E  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_SE = 3'd3;
   localparam logic [DIR_W-1:0] DIR_S  = 3'd4;
   localparam logic [DIR_W-1:0] DIR_SW = 3'd5;
   localparam logic [DIR_W-1:0] DIR_W_ = 3'd6;
   localparam logic [DIR_W-1:0] DIR_NW = 3'd7;

   localparam logic [OUT_W-1:0] OUT_PATH     = 2'd0;
   localparam logic [OUT_W-1:0] OUT_NO_PATH  = 2'd1;
   localparam logic [OUT_W-1:0] OUT_OVERFLOW = 2'd2;

   localparam logic [1:0] CSR_ROWS_USED = 2'd0;
   localparam logic [1:0] CSR_COLS_USED = 2'd1;

   localparam logic [COORD_W-1:0] ROWS_USED_RST = 5'd11;
   localparam logic [COORD_W-1:0] COLS_USED_RST = 5'd15;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [DIR_W-1:0]   dir;
   } stack_entry_type;

   typedef struct packed {
      logic [NB_W-1:0] row;
      logic [NB_W-1:0] col;
      logic            in_grid;
      logic            at_goal;
   } probe_type;

   // row step, two's complement
   function automatic logic [NB_W-1:0] dir_dr(input logic [DIR_W-1:0] d);
      logic [NB_W-1:0] r;
      unique case (d)
         DIR_N, DIR_NE, DIR_NW: r = '1;
         DIR_SE, DIR_S, DIR_SW: r = 6'd1;
         default:               r = '0;
      endcase
      return r;
   endfunction

   // column step, two's complement
   function automatic logic [NB_W-1:0] dir_dc(input logic [DIR_W-1:0] d);
      logic [NB_W-1:0] r;
      unique case (d)
         DIR_NE, DIR_E, DIR_SE:  r = 6'd1;
         DIR_SW, DIR_W_, DIR_NW: r = '1;
         default:                r = '0;
      endcase
      return r;
   endfunction

   // trial order E,S,W,N,SE,SW,NW,NE; bit 3 set once all are tried
   function automatic logic [DIR_W:0] dir_next(input logic [DIR_W-1:0] d);
      logic [DIR_W:0] r;
      unique case (d)
         DIR_N:   r = {1'b0, DIR_SE};
         DIR_NE:  r = 4'b1000;
         DIR_E:   r = {1'b0, DIR_S};
         DIR_SE:  r = {1'b0, DIR_SW};
         DIR_S:   r = {1'b0, DIR_W_};
         DIR_SW:  r = {1'b0, DIR_NW};
         DIR_W_:  r = {1'b0, DIR_N};
         default: r = {1'b0, DIR_NE};
      endcase
      return r;
   endfunction

endpackage

### rtl/maze_path_search.sv
`timescale 1ns / 1ps
// Maze path search, depth-first walk over eight neighbours.
// req_ channel: func 0 writes one wall bit at (cell_row, cell_col) when that cell
//   lies in the grid, and gives no rsp beat. func 1 starts a search.
// rsp_ channel: one beat per path cell from goal back to start, or a single
//   beat with outcome no-path or overflow; last marks the final beat.
// csr_ channel: index 0 rows_used, index 1 cols_used; always ready.
// Search steps: a clearing pass over the visited map of GRID_ROWS*GRID_COLS
//   cells (256 by default), then each neighbour is tried through the single
//   probe unit and the registered map read, back-up steps restore a cell from
//   the stack, and each rsp beat is read through the stack memory port.
// req_ready is high only while no search runs and no rsp beat is pending,
//   so one item is in work at a time.
// A stalled receiver holds the rsp beat in the output register; the walk
//   waits until it is taken.
// Reset returns to idle with no rsp beat pending and restores rows_used 11
//   and cols_used 15; wall contents are kept as written.
module maze_path_search #(
   parameter int GRID_ROWS   = mps_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS   = mps_pkg::GRID_COLS_DEF,
   parameter int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [mps_pkg::COORD_W-1:0] req_cell_row,
   input  logic [mps_pkg::COORD_W-1:0] req_cell_col,
   input  logic                        req_wall,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mps_pkg::COORD_W-1:0] rsp_step_row,
   output logic [mps_pkg::COORD_W-1:0] rsp_step_col,
   output logic [mps_pkg::DIR_W-1:0]   rsp_step_dir,
   output logic [mps_pkg::OUT_W-1:0]   rsp_outcome,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [mps_pkg::COORD_W-1:0] csr_data
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SA_W   = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [mps_pkg::LIM_W-1:0] ROW_LIM  = mps_pkg::LIM_W'(GRID_ROWS);
   localparam logic [mps_pkg::LIM_W-1:0] COL_LIM  = mps_pkg::LIM_W'(GRID_COLS);
   localparam logic [ADDR_W-1:0]         CLR_LAST = ADDR_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]          CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0]          CNT_TOP  = CNT_W'(STACK_DEPTH - 1);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_CLEAR   = 10'b00_0000_0010,
      ST_PROBE   = 10'b00_0000_0100,
      ST_CHECK   = 10'b00_0000_1000,
      ST_DEAD    = 10'b00_0001_0000,
      ST_RESTORE = 10'b00_0010_0000,
      ST_GOAL    = 10'b00_0100_0000,
      ST_READ    = 10'b00_1000_0000,
      ST_LOAD    = 10'b01_0000_0000,
      ST_WAIT    = 10'b10_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [mps_pkg::COORD_W-1:0] rows_used_ff, rows_used_in;
   logic [mps_pkg::COORD_W-1:0] cols_used_ff, cols_used_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [mps_pkg::COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [mps_pkg::COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [mps_pkg::DIR_W-1:0]   try_dir_ff, try_dir_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mps_pkg::COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [mps_pkg::COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [mps_pkg::DIR_W-1:0]   rsp_dir_ff, rsp_dir_in;
   logic [mps_pkg::OUT_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [mps_pkg::LIM_W-1:0]   goal_row;
   logic [mps_pkg::LIM_W-1:0]   goal_col;
   logic                        idle;
   mps_pkg::probe_type          probe;
   logic [ADDR_W-1:0]           cell_addr;
   logic [mps_pkg::DIR_W:0]     nxt_dir;
   logic                        wall_we;
   logic                        vis_we;
   logic                        vis_wdata;
   logic [ADDR_W-1:0]           vis_waddr;
   logic                        wall_rd;
   logic                        vis_rd;
   logic                        stk_we;
   mps_pkg::stack_entry_type    stk_wdata;
   mps_pkg::stack_entry_type    stk_rdata;
   logic [CNT_W-1:0]            count_m1;

   assign idle = (state_ff == ST_IDLE);

   // rows_used/cols_used clamped to 1..grid size
   assign goal_row = (rows_used_ff == '0) ? 7'd1 :
                     (({2'b0, rows_used_ff} > ROW_LIM) ? ROW_LIM : {2'b0, rows_used_ff});
   assign goal_col = (cols_used_ff == '0) ? 7'd1 :
                     (({2'b0, cols_used_ff} > COL_LIM) ? COL_LIM : {2'b0, cols_used_ff});

   mps_probe #(
      .GRID_COLS (GRID_COLS),
      .ADDR_W    (ADDR_W)
   ) u_probe (
      .base_row (idle ? req_cell_row : cur_row_ff),
      .base_col (idle ? req_cell_col : cur_col_ff),
      .dir      (try_dir_ff),
      .step_en  (!idle),
      .lim_row  (idle ? ROW_LIM : goal_row),
      .lim_col  (idle ? COL_LIM : goal_col),
      .probe    (probe),
      .addr     (cell_addr)
   );

   mps_grid #(
      .CELLS  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_grid (
      .clock      (clock),
      .wall_we    (wall_we),
      .wall_wdata (req_wall),
      .vis_we     (vis_we),
      .vis_wdata  (vis_wdata),
      .vis_waddr  (vis_waddr),
      .addr       (cell_addr),
      .wall_rd    (wall_rd),
      .vis_rd     (vis_rd)
   );

   assign count_m1 = count_ff - 1'b1;

   mps_stack #(
      .DEPTH (STACK_DEPTH),
      .SA_W  (SA_W)
   ) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (count_ff[SA_W-1:0]),
      .wdata (stk_wdata),
      .raddr (count_m1[SA_W-1:0]),
      .rdata (stk_rdata)
   );

   assign nxt_dir = mps_pkg::dir_next(try_dir_ff);

   assign wall_we = idle && req_valid && !req_func && probe.in_grid;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      try_dir_in     = try_dir_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_last_in    = rsp_last_ff;
      vis_we         = 1'b0;
      vis_wdata      = 1'b1;
      vis_waddr      = cell_addr;
      stk_we         = 1'b0;
      stk_wdata      = '{row: cur_row_ff, col: cur_col_ff, dir: try_dir_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_func) begin
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            // start cell ends up marked
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = (clr_ff == '0);
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               count_in   = '0;
               cur_row_in = 5'd1;
               cur_col_in = 5'd1;
               try_dir_in = mps_pkg::DIR_E;
               if (goal_row == 7'd1 && goal_col == 7'd1) begin
                  rsp_valid_in   = 1'b1;
                  rsp_row_in     = 5'd1;
                  rsp_col_in     = 5'd1;
                  rsp_dir_in     = mps_pkg::DIR_E;
                  rsp_outcome_in = mps_pkg::OUT_PATH;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_WAIT;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (probe.in_grid) begin
               state_in = ST_CHECK;
            end else if (nxt_dir[mps_pkg::DIR_W]) begin
               state_in = ST_DEAD;
            end else begin
               try_dir_in = nxt_dir[mps_pkg::DIR_W-1:0];
            end
         end
         ST_CHECK: begin
            if (vis_rd || wall_rd) begin
               if (nxt_dir[mps_pkg::DIR_W]) begin
                  state_in = ST_DEAD;
               end else begin
                  try_dir_in = nxt_dir[mps_pkg::DIR_W-1:0];
                  state_in   = ST_PROBE;
               end
            end else if (count_ff == CNT_FULL) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = '0;
               rsp_col_in     = '0;
               rsp_dir_in     = mps_pkg::DIR_N;
               rsp_outcome_in = mps_pkg::OUT_OVERFLOW;
               rsp_last_in    = 1'b1;
               state_in       = ST_WAIT;
            end else begin
               stk_we     = 1'b1;
               vis_we     = 1'b1;
               count_in   = count_ff + 1'b1;
               cur_row_in = probe.row[mps_pkg::COORD_W-1:0];
               cur_col_in = probe.col[mps_pkg::COORD_W-1:0];
               try_dir_in = mps_pkg::DIR_E;
               if (!probe.at_goal) begin
                  state_in = ST_PROBE;
               end else if (count_ff == CNT_TOP) begin
                  rsp_valid_in   = 1'b1;
                  rsp_row_in     = '0;
                  rsp_col_in     = '0;
                  rsp_dir_in     = mps_pkg::DIR_N;
                  rsp_outcome_in = mps_pkg::OUT_OVERFLOW;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_WAIT;
               end else begin
                  state_in = ST_GOAL;
               end
            end
         end
         ST_DEAD: begin
            if (count_ff == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = '0;
               rsp_col_in     = '0;
               rsp_dir_in     = mps_pkg::DIR_N;
               rsp_outcome_in = mps_pkg::OUT_NO_PATH;
               rsp_last_in    = 1'b1;
               state_in       = ST_WAIT;
            end else begin
               count_in = count_m1;
               state_in = ST_RESTORE;
            end
         end
         ST_RESTORE: begin
            cur_row_in = stk_rdata.row;
            cur_col_in = stk_rdata.col;
            try_dir_in = mps_pkg::DIR_E;
            state_in   = ST_PROBE;
         end
         ST_GOAL: begin
            stk_we    = 1'b1;
            stk_wdata = '{row: cur_row_ff, col: cur_col_ff, dir: mps_pkg::DIR_E};
            count_in  = count_ff + 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            count_in = count_m1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in   = 1'b1;
            rsp_row_in     = stk_rdata.row;
            rsp_col_in     = stk_rdata.col;
            rsp_dir_in     = stk_rdata.dir;
            rsp_outcome_in = mps_pkg::OUT_PATH;
            rsp_last_in    = (count_ff == '0);
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mps_pkg::CSR_ROWS_USED: rows_used_in = csr_data;
            mps_pkg::CSR_COLS_USED: cols_used_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_used_ff <= mps_pkg::ROWS_USED_RST;
         cols_used_ff <= mps_pkg::COLS_USED_RST;
         count_ff     <= '0;
         cur_row_ff   <= 5'd1;
         cur_col_ff   <= 5'd1;
         try_dir_ff   <= mps_pkg::DIR_E;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         count_ff     <= count_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         try_dir_ff   <= try_dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff         <= clr_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ready    = idle;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_step_row = rsp_row_ff;
   assign rsp_step_col = rsp_col_ff;
   assign rsp_step_dir = rsp_dir_ff;
   assign rsp_outcome  = rsp_outcome_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/mps_probe.sv
`timescale 1ns / 1ps

module mps_probe #(
   parameter int GRID_COLS = mps_pkg::GRID_COLS_DEF,
   parameter int ADDR_W    = 8
) (
   input  logic [mps_pkg::COORD_W-1:0] base_row,
   input  logic [mps_pkg::COORD_W-1:0] base_col,
   input  logic [mps_pkg::DIR_W-1:0]   dir,
   input  logic                        step_en,
   input  logic [mps_pkg::LIM_W-1:0]   lim_row,
   input  logic [mps_pkg::LIM_W-1:0]   lim_col,
   output mps_pkg::probe_type          probe,
   output logic [ADDR_W-1:0]           addr
);

   localparam int PROD_W = mps_pkg::NB_W + $clog2(GRID_COLS + 1) + 1;

   logic [mps_pkg::NB_W-1:0] nr;
   logic [mps_pkg::NB_W-1:0] nc;
   logic [mps_pkg::NB_W-1:0] dr;
   logic [mps_pkg::NB_W-1:0] dc;
   logic [PROD_W-1:0]        lin;

   assign dr = step_en ? mps_pkg::dir_dr(dir) : '0;
   assign dc = step_en ? mps_pkg::dir_dc(dir) : '0;
   assign nr = {1'b0, base_row} + dr;
   assign nc = {1'b0, base_col} + dc;

   assign lin = PROD_W'(nr - 6'd1) * PROD_W'(GRID_COLS) + PROD_W'(nc - 6'd1);

   assign probe.row     = nr;
   assign probe.col     = nc;
   assign probe.in_grid = (nr != '0) && (nc != '0) &&
                          ({1'b0, nr} <= lim_row) && ({1'b0, nc} <= lim_col);
   assign probe.at_goal = ({1'b0, nr} == lim_row) && ({1'b0, nc} == lim_col);
   assign addr          = lin[ADDR_W-1:0];

endmodule

### rtl/mps_grid.sv
`timescale 1ns / 1ps

module mps_grid #(
   parameter int CELLS  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wall_we,
   input  logic              wall_wdata,
   input  logic              vis_we,
   input  logic              vis_wdata,
   input  logic [ADDR_W-1:0] vis_waddr,
   input  logic [ADDR_W-1:0] addr,
   output logic              wall_rd,
   output logic              vis_rd
);

   logic wall_mem_ff [CELLS];
   logic vis_mem_ff  [CELLS];
   logic wall_rd_ff;
   logic vis_rd_ff;

   // loads write through the same address path the walk reads with
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem_ff[addr] <= wall_wdata;
      end
      wall_rd_ff <= wall_mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem_ff[vis_waddr] <= vis_wdata;
      end
      vis_rd_ff <= vis_mem_ff[addr];
   end

   assign wall_rd = wall_rd_ff;
   assign vis_rd  = vis_rd_ff;

endmodule

### rtl/mps_stack.sv
`timescale 1ns / 1ps

module mps_stack #(
   parameter int DEPTH = mps_pkg::STACK_DEPTH_DEF,
   parameter int SA_W  = 6
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [SA_W-1:0]          waddr,
   input  mps_pkg::stack_entry_type wdata,
   input  logic [SA_W-1:0]          raddr,
   output mps_pkg::stack_entry_type rdata
);

   mps_pkg::stack_entry_type mem_ff [DEPTH];
   mps_pkg::stack_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/mps_checker.sv
`timescale 1ns / 1ps
`include "maze_path_search_defines.svh"

module mps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mps_pkg::COORD_W-1:0] rsp_step_row,
   input logic [mps_pkg::COORD_W-1:0] rsp_step_col,
   input logic [mps_pkg::DIR_W-1:0]   rsp_step_dir,
   input logic [mps_pkg::OUT_W-1:0]   rsp_outcome,
   input logic                        rsp_last
);

   // stalled beat holds
   `MPS_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_step_row) && $stable(rsp_step_col) && $stable(rsp_step_dir) && $stable(rsp_outcome) && $stable(rsp_last), "rsp beat changed while stalled")

   // no new request while a result is pending
   `MPS_CHECK_NOW(a_busy, rsp_valid, !req_ready, "req_ready high with rsp beat pending")

   // failure beats stand alone and carry no cell
   `MPS_CHECK_NOW(a_fail_beat, rsp_valid && (rsp_outcome != mps_pkg::OUT_PATH), rsp_last && ((rsp_outcome == mps_pkg::OUT_NO_PATH) || (rsp_outcome == mps_pkg::OUT_OVERFLOW)) && (rsp_step_row == '0) && (rsp_step_col == '0), "bad failure beat")

   // run ends after the last beat
   `MPS_CHECK_NEXT(a_run_end, rsp_valid && rsp_ready && rsp_last, !rsp_valid && req_ready, "no return to idle after last beat")

endmodule

bind maze_path_search mps_checker u_mps_checker (.*);

### verif/tb_maze_path_search.sv
`timescale 1ns / 1ps

module tb_maze_path_search;
   import mps_pkg::*;

   localparam int CELLS          = GRID_ROWS_DEF * GRID_COLS_DEF;
   localparam int RANDOM_ITEMS   = 190;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int LONG_STALL     = 400;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // register slots past the two defined ones; writes there change nothing
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               wall;
   } maze_cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [DIR_W-1:0]   dir;
      logic [OUT_W-1:0]   outcome;
      logic               last;
   } route_step_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = FUNC_LOAD;
   logic [COORD_W-1:0] req_cell_row = '0;
   logic [COORD_W-1:0] req_cell_col = '0;
   logic               req_wall = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COORD_W-1:0] rsp_step_row;
   logic [COORD_W-1:0] rsp_step_col;
   logic [DIR_W-1:0]   rsp_step_dir;
   logic [OUT_W-1:0]   rsp_outcome;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [COORD_W-1:0] csr_data = '0;

   maze_cmd_type   cmd_q[$];
   maze_cmd_type   head_cmd;
   route_step_type route_q[$];
   route_step_type want;

   // predictor state
   bit                 wall_bits [CELLS];
   logic [COORD_W-1:0] cfg_rows = ROWS_USED_RST;
   logic [COORD_W-1:0] cfg_cols = COLS_USED_RST;

   int send_gap_pct = 31;
   int take_gap_pct = 50;
   int holds_asked = 0;
   int holds_served = 0;
   int stall_left = 0;
   int quiet = 0;

   int n_err = 0;
   int n_load = 0;
   int n_csr = 0;
   int n_beat = 0;
   int n_path = 0;
   int n_nopath = 0;
   int n_ovf = 0;

   maze_path_search i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_cell_row (req_cell_row),
      .req_cell_col (req_cell_col),
      .req_wall     (req_wall),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_step_row (rsp_step_row),
      .rsp_step_col (rsp_step_col),
      .rsp_step_dir (rsp_step_dir),
      .rsp_outcome  (rsp_outcome),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int fold_dim(int v, int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic logic [DIR_W-1:0] trial_dir(int k);
      case (k)
         0:       return DIR_E;
         1:       return DIR_S;
         2:       return DIR_W_;
         3:       return DIR_N;
         4:       return DIR_SE;
         5:       return DIR_SW;
         6:       return DIR_NW;
         default: return DIR_NE;
      endcase
   endfunction

   function automatic int row_step(logic [DIR_W-1:0] d);
      case (d)
         DIR_N, DIR_NE, DIR_NW: return -1;
         DIR_S, DIR_SE, DIR_SW: return 1;
         default:               return 0;
      endcase
   endfunction

   function automatic int col_step(logic [DIR_W-1:0] d);
      case (d)
         DIR_E, DIR_NE, DIR_SE:  return 1;
         DIR_W_, DIR_NW, DIR_SW: return -1;
         default:                return 0;
      endcase
   endfunction

   function automatic void push_verdict(logic [OUT_W-1:0] oc);
      route_step_type v;
      v = '0;
      v.outcome = oc;
      v.last = 1'b1;
      route_q.push_back(v);
   endfunction

   // depth-first walk over the current wall map; fills route_q
   function automatic void plan_route();
      bit               seen [CELLS];
      route_step_type   trail [STACK_DEPTH_DEF];
      route_step_type   hop;
      logic [DIR_W-1:0] d;
      bit               passable;
      int               gr, gc, depth, r, c, nr, nc, k, idx;
      gr = fold_dim(cfg_rows, GRID_ROWS_DEF);
      gc = fold_dim(cfg_cols, GRID_COLS_DEF);
      foreach (seen[i]) seen[i] = 1'b0;
      seen[0] = 1'b1;
      depth = 0;
      r = 1;
      c = 1;
      k = 0;
      if (gr == 1 && gc == 1) begin
         hop.row = 1;
         hop.col = 1;
         hop.dir = DIR_E;
         hop.outcome = OUT_PATH;
         hop.last = 1'b1;
         route_q.push_back(hop);
         return;
      end
      forever begin
         while (k < 8) begin
            d = trial_dir(k);
            nr = r + row_step(d);
            nc = c + col_step(d);
            passable = 1'b0;
            idx = 0;
            if (nr >= 1 && nr <= gr && nc >= 1 && nc <= gc) begin
               idx = (nr - 1) * GRID_COLS_DEF + (nc - 1);
               passable = !seen[idx] && !wall_bits[idx];
            end
            if (!passable) begin
               k++;
               continue;
            end
            if (depth >= STACK_DEPTH_DEF) begin
               push_verdict(OUT_OVERFLOW);
               return;
            end
            trail[depth].row = COORD_W'(r);
            trail[depth].col = COORD_W'(c);
            trail[depth].dir = d;
            depth++;
            seen[idx] = 1'b1;
            r = nr;
            c = nc;
            k = 0;
            if (r == gr && c == gc) begin
               if (depth >= STACK_DEPTH_DEF) begin
                  push_verdict(OUT_OVERFLOW);
                  return;
               end
               trail[depth].row = COORD_W'(r);
               trail[depth].col = COORD_W'(c);
               trail[depth].dir = DIR_E;
               depth++;
               while (depth > 0) begin
                  depth--;
                  hop = trail[depth];
                  hop.outcome = OUT_PATH;
                  hop.last = (depth == 0);
                  route_q.push_back(hop);
               end
               return;
            end
         end
         // dead end: cell stays marked, back up
         if (depth == 0) begin
            push_verdict(OUT_NO_PATH);
            return;
         end
         depth--;
         r = trail[depth].row;
         c = trail[depth].col;
         k = 0;
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         n_err++;
      end
   endfunction

   // req driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            head_cmd = cmd_q.pop_front();
            req_valid <= 1'b1;
            req_func <= head_cmd.func;
            req_cell_row <= head_cmd.row;
            req_cell_col <= head_cmd.col;
            req_wall <= head_cmd.wall;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // rsp ready, with the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (holds_served != holds_asked && rsp_valid) begin
         rsp_ready <= 1'b0;
         stall_left <= LONG_STALL;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= take_gap_pct);
      end
   end

   // predictor update and result check
   always @(posedge clock) begin
      if (reset) begin
         cfg_rows = ROWS_USED_RST;
         cfg_cols = COLS_USED_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            n_csr++;
            if (csr_index == CSR_ROWS_USED) begin
               cfg_rows = csr_data;
            end else if (csr_index == CSR_COLS_USED) begin
               cfg_cols = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            if (req_func == FUNC_SEARCH) begin
               plan_route();
            end else begin
               n_load++;
               if (req_cell_row >= 1 && req_cell_row <= GRID_ROWS_DEF &&
                   req_cell_col >= 1 && req_cell_col <= GRID_COLS_DEF) begin
                  wall_bits[(req_cell_row - 1) * GRID_COLS_DEF + (req_cell_col - 1)] = req_wall;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            n_beat++;
            if (route_q.size() == 0) begin
               $error("result beat with nothing expected: row %0d col %0d outcome %0d",
                      rsp_step_row, rsp_step_col, rsp_outcome);
               n_err++;
            end else begin
               want = route_q.pop_front();
               check_field("step_row", want.row, rsp_step_row);
               check_field("step_col", want.col, rsp_step_col);
               check_field("step_dir", want.dir, rsp_step_dir);
               check_field("outcome", want.outcome, rsp_outcome);
               check_field("last", want.last, rsp_last);
               if (want.last) begin
                  case (want.outcome)
                     OUT_PATH:    n_path++;
                     OUT_NO_PATH: n_nopath++;
                     default:     n_ovf++;
                  endcase
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic put_load(int r, int c, bit w);
      maze_cmd_type m;
      m.func = FUNC_LOAD;
      m.row = COORD_W'(r);
      m.col = COORD_W'(c);
      m.wall = w;
      cmd_q.push_back(m);
   endtask

   task automatic put_search();
      maze_cmd_type m;
      m.func = FUNC_SEARCH;
      m.row = COORD_W'($urandom_range(31));
      m.col = COORD_W'($urandom_range(31));
      m.wall = 1'($urandom_range(1));
      cmd_q.push_back(m);
   endtask

   task automatic settle();
      do @(negedge clock); while (cmd_q.size() != 0 || req_valid || route_q.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= COORD_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_dims(int r, int c);
      settle();
      write_reg(CSR_ROWS_USED, r);
      write_reg(CSR_COLS_USED, c);
   endtask

   task automatic put_noise_load();
      if ($urandom_range(1)) begin
         put_load($urandom_range(1) ? 0 : $urandom_range(17, 31), $urandom_range(31),
                  $urandom_range(1));
      end else begin
         put_load($urandom_range(31), $urandom_range(1) ? 0 : $urandom_range(17, 31),
                  $urandom_range(1));
      end
   endtask

   initial begin
      int r, c, dr, dc, gr, gc, density, pick, rand_cnt;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // whole grid: serpentine in columns 1..8 (row 16 blocked), random walls beyond
      for (r = 1; r <= GRID_ROWS_DEF; r++) begin
         for (c = 1; c <= GRID_COLS_DEF; c++) begin
            if (c > 8) begin
               put_load(r, c, $urandom_range(99) < 30);
            end else if (r == 16) begin
               put_load(r, c, 1'b1);
            end else if (r % 2 == 1) begin
               put_load(r, c, 1'b0);
            end else begin
               put_load(r, c, c != (((r / 2) % 2 == 1) ? 8 : 1));
            end
         end
      end
      put_search();

      // overflow on a step push
      set_dims(16, 8);
      put_search();

      // 63 steps: 64-beat path under a long receiver hold-off
      set_dims(15, 8);
      holds_asked = holds_asked + 1;
      put_search();
      put_load(16, 8, 1'b0);
      put_load(0, 5, 1'b1);
      put_load(17, 3, 1'b1);
      put_load(4, 0, 1'b1);
      put_load(31, 31, 1'b1);

      // 64 steps: overflow on the goal push
      set_dims(16, 8);
      put_search();

      set_dims(1, 1);
      put_search();
      set_dims(0, 0);
      put_search();

      // dead end with back-up, then no path
      set_dims(2, 2);
      put_search();

      // blocked start cell is not looked at
      put_load(1, 1, 1'b1);
      set_dims(1, 3);
      put_search();
      put_load(1, 1, 1'b0);

      set_dims(31, 31);
      write_reg(CSR_SPARE_2, 7);
      write_reg(CSR_SPARE_3, 20);
      put_search();
      set_dims(16, 16);
      put_search();

      rand_cnt = 0;
      while (rand_cnt < RANDOM_ITEMS) begin
         if (rand_cnt >= 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end else if (rand_cnt >= RANDOM_ITEMS / 3) begin
            send_gap_pct = 50;
            take_gap_pct = 31;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            dr = $urandom_range(2, 6);
            dc = $urandom_range(2, 6);
         end else if (pick < 92) begin
            dr = $urandom_range(1, 16);
            dc = $urandom_range(1, 16);
         end else begin
            dr = $urandom_range(0, 31);
            dc = $urandom_range(0, 31);
         end
         set_dims(dr, dc);
         gr = fold_dim(dr, GRID_ROWS_DEF);
         gc = fold_dim(dc, GRID_COLS_DEF);
         density = $urandom_range(5, 45);
         if (gr * gc <= 40) begin
            for (r = 1; r <= gr; r++) begin
               for (c = 1; c <= gc; c++) begin
                  put_load(r, c, $urandom_range(99) < density);
                  rand_cnt++;
               end
            end
         end else begin
            repeat (20) begin
               put_load($urandom_range(1, gr), $urandom_range(1, gc),
                        $urandom_range(99) < density);
               rand_cnt++;
            end
         end
         if ($urandom_range(9) != 0) begin
            put_load(gr, gc, 1'b0);
            rand_cnt++;
         end
         repeat ($urandom_range(2)) put_noise_load();
         put_search();
         rand_cnt++;
         if ($urandom_range(99) < 40) begin
            repeat ($urandom_range(1, 4)) begin
               put_load($urandom_range(1, gr), $urandom_range(1, gc), $urandom_range(1));
               rand_cnt++;
            end
            put_search();
            rand_cnt++;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("tb: %0d searches checked: %0d paths, %0d without path, %0d overflows",
               n_path + n_nopath + n_ovf, n_path, n_nopath, n_ovf);
      $display("tb: %0d result beats, %0d cell loads, %0d register writes",
               n_beat, n_load, n_csr);
      if (n_err == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
